// ----- rtl/core/icpm_pkg.sv -----
// ============================================================================
// icpm_pkg
// Shared types, constants and modular helpers for the Mahonian number unit.
// ============================================================================
package icpm_pkg;

    // Width of one table entry and of the result word.
    localparam int DATA_W = 30;

    // Prime modulus of every table entry.
    localparam logic [DATA_W-1:0] MOD_P = 30'd1000000007;

    // Control states of the query sequencer.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Modular add of two reduced values with one conditional correction.
    function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MOD_P}) begin
            s = s - {1'b0, MOD_P};
        end
        return s[DATA_W-1:0];
    endfunction

    // Modular subtract of two reduced values with one conditional correction.
    function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + (MOD_P - b);
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/inversion_count_permutations_mod_unit.sv -----
// ============================================================================
// inversion_count_permutations_mod_unit
// Counts permutations of 1..n with exactly k inversions, modulo 1000000007,
// by building the Mahonian table one entry per cycle through two cell chains.
// ============================================================================
//
//  channel  | dir | tdata bits (low to high)        | accepted when
//  ---------+-----+---------------------------------+----------------------------
//  s_axis   | in  | n_size[9:0], k_target[19:10]    | s_axis_tvalid & s_axis_tready
//  m_axis   | out | count_mod[29:0]                 | m_axis_tvalid & m_axis_tready
//
// A query is loaded, then walks rows 0..n of columns 0..k, one table entry
// per cycle through the row-ring chain.
// Out-of-range queries return zero.
// Reset (synchronous, active low) clears only the control state; the chains
// are refilled from row zero by every query.
// The final entry waits while the previous result is still unclaimed; the
// input side is ready again as soon as the last entry is stored.
//
module inversion_count_permutations_mod_unit #(
    parameter int MAX_N = 1023,
    parameter int MAX_K = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // n_size[9:0], k_target[19:10], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // count_mod[29:0], zeros
);
    import icpm_pkg::*;

    localparam int NW    = $clog2(MAX_N + 1);
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int TAP_W = (NW > KW) ? NW : KW;

    t_state            r_state;
    t_state            n_state;
    logic [NW-1:0]     r_n;
    logic [NW-1:0]     r_i;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_j;
    logic              r_zero;
    logic [DATA_W-1:0] r_left;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic [9:0]        in_n;
    logic [9:0]        in_k;
    logic              in_accept;
    logic              out_range;
    logic              last;
    logic              step;
    logic              row_end;
    logic [DATA_W-1:0] ring_head;
    logic [DATA_W-1:0] dly_head;
    logic [DATA_W-1:0] sum_v;
    logic [DATA_W-1:0] entry_v;
    logic [TAP_W-1:0]  ring_tap;
    logic [TAP_W-1:0]  dly_tap;

    // Input word unpacking.
    assign in_n      = s_axis_tdata[9:0];
    assign in_k      = s_axis_tdata[19:10];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_range = (32'(in_n) > MAX_N) || (32'(in_k) > MAX_K);

    // Position in the table walk.
    assign row_end = (r_j == r_k);
    assign last    = row_end && (r_i == r_n);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step && last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Ready while idle; one entry per cycle while running, the last may be held.
    always_comb begin
        s_axis_tready = 1'b0;
        step          = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RUN:  step = !(last && r_out_valid && !m_axis_tready);
            default: begin
                s_axis_tready = 1'b0;
                step          = 1'b0;
            end
        endcase
    end

    // New table entry: left neighbor plus the entry above, minus the entry
    // above and i columns to the left once j reaches i. Row zero is 1,0,0...
    assign sum_v = mod_add((r_j == '0) ? '0 : r_left, ring_head);

    always_comb begin
        if (r_i == '0) begin
            entry_v = (r_j == '0) ? DATA_W'(1) : '0;
        end else if (TAP_W'(r_j) >= TAP_W'(r_i)) begin
            entry_v = mod_sub(sum_v, dly_head);
        end else begin
            entry_v = sum_v;
        end
    end

    // The ring closes after k+1 shifts; the delay line after i shifts.
    assign ring_tap = TAP_W'(r_k);
    assign dly_tap  = TAP_W'(r_i) - TAP_W'(1);

    icpm_chain #(
        .DEPTH (MAX_K + 1),
        .TAP_W (TAP_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_shift (step),
        .i_tap   (ring_tap),
        .i_ins   (entry_v),
        .o_head  (ring_head)
    );

    icpm_chain #(
        .DEPTH (MAX_K),
        .TAP_W (TAP_W)
    ) u_delay (
        .i_clk   (i_clk),
        .i_shift (step),
        .i_tap   (dly_tap),
        .i_ins   (ring_head),
        .o_head  (dly_head)
    );

    // Control registers and walk counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_zero      <= 1'b0;
        end else begin
            r_state <= n_state;
            // A new result takes precedence over the one being taken.
            if (step && last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                r_i    <= '0;
                r_j    <= '0;
                r_zero <= out_range;
                r_n    <= out_range ? '0 : NW'(in_n);
                r_k    <= out_range ? '0 : KW'(in_k);
            end else if (step) begin
                if (row_end) begin
                    r_j <= '0;
                    r_i <= r_i + NW'(1);
                end else begin
                    r_j <= r_j + KW'(1);
                end
            end
        end
    end

    // Left-neighbor register and result word.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_left <= entry_v;
            if (last) begin
                r_out_data <= r_zero ? '0 : entry_v;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data};

`ifndef SYNTHESIS
    // The column counter never passes the last requested column.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_j <= r_k))
        else $error("column counter beyond k");

    // The row counter never passes n.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_i <= r_n))
        else $error("row counter beyond n");

    // An accepted query starts the table walk in the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_RUN) && (r_i == '0) && (r_j == '0))
        else $error("query did not start");

    // Storing the last entry always presents a result.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last) |=> m_axis_tvalid && (r_state == ST_IDLE))
        else $error("last entry did not produce a result");

    // The last entry is never stored over an unclaimed result.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last) |-> (!r_out_valid || m_axis_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ----- rtl/core/icpm_cell.sv -----
// ============================================================================
// icpm_cell
// One storage cell of a shifting delay chain: takes its upper neighbor's word
// on every shift, or the inserted word when the tap points at this cell.
// ============================================================================
module icpm_cell #(
    parameter int CELL_IDX = 0,
    parameter int TAP_W    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic [TAP_W-1:0]          i_tap,
    input  logic [icpm_pkg::DATA_W-1:0] i_ins,
    input  logic [icpm_pkg::DATA_W-1:0] i_upper,
    output logic [icpm_pkg::DATA_W-1:0] o_data
);
    import icpm_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic              hit;

    // The tap selects the cell that takes the newly inserted word.
    assign hit = (i_tap == TAP_W'(CELL_IDX));

    // Payload only: contents are rebuilt by every query, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= hit ? i_ins : i_upper;
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/icpm_chain.sv -----
// ============================================================================
// icpm_chain
// A row of cells forming a delay line whose length is set by the tap: a word
// inserted at tap T reaches the head T+1 shifts later.
// ============================================================================
module icpm_chain #(
    parameter int DEPTH = 1024,
    parameter int TAP_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [TAP_W-1:0]            i_tap,
    input  logic [icpm_pkg::DATA_W-1:0] i_ins,
    output logic [icpm_pkg::DATA_W-1:0] o_head
);
    import icpm_pkg::*;

    // Cell outputs; one extra slot feeds zeros into the top cell.
    logic [DATA_W-1:0] cell_q [DEPTH+1];

    assign cell_q[DEPTH] = '0;

    // Each cell passes its word one place toward the head per shift.
    for (genvar c = 0; c < DEPTH; c++) begin : g_cell
        icpm_cell #(
            .CELL_IDX (c),
            .TAP_W    (TAP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_tap   (i_tap),
            .i_ins   (i_ins),
            .i_upper (cell_q[c+1]),
            .o_data  (cell_q[c])
        );
    end

    assign o_head = cell_q[0];

endmodule
